### sv/centered_sliding_sum_core_macros.svh
// Assertion macros shared by the checker of the centered sliding-sum core.
// Needs nothing else; include by bare file name.
`ifndef CENTERED_SLIDING_SUM_CORE_MACROS_SVH
`define CENTERED_SLIDING_SUM_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define CSS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is high
`define CSS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycles
`define CSS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### sv/css_pkg.sv
// Shared constants, command codes and types of the centered sliding-sum core.
// No dependencies; imported by css_scale, centered_sliding_sum_core and the testbench.
`timescale 1ns / 1ps

package css_pkg;

  // Default delay line depth (largest usable window)
  localparam int DEF_WINDOW_DEPTH = 1024;

  // Fixed field widths
  localparam int SAMPLE_W   = 32;
  localparam int CMD_W      = 2;
  localparam int WIN_W      = 11;
  localparam int PEND_W     = WIN_W - 1;
  localparam int RECIP_W    = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // Running sum and scaling arithmetic
  localparam int SUM_W           = 48;
  localparam int SPLIT_BITS      = 24;
  localparam int RECIP_FRAC_BITS = 16;

  // Commands carried on tuser
  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAIL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DENOM_RECIP = 1'b1;

  // Register reset values and window floor
  localparam logic [WIN_W-1:0]          WINDOW_RESET = 11'd100;
  localparam logic [WIN_W-1:0]          WINDOW_MIN   = 11'd3;
  localparam logic signed [RECIP_W-1:0] RECIP_RESET  = 24'sd65536;

  // One window sum on its way to the scaler
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } css_item_t;

endpackage

### sv/css_scale.sv
// Reciprocal scaling of window sums: split multiply, round, saturate to 32 bits.
// Holds one product stage and the output word register. Depends on css_pkg.
`timescale 1ns / 1ps

module css_scale import css_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  css_item_t                   in_item,
  input  logic signed [RECIP_W-1:0]   recip,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SAMPLE_W-1:0]  out_value,
  output logic                        out_last
);

  localparam int HI_W  = SUM_W - SPLIT_BITS;
  localparam int PHI_W = HI_W + RECIP_W;
  localparam int PLO_W = SPLIT_BITS + 1 + RECIP_W;
  localparam int RES_W = PHI_W + SPLIT_BITS - RECIP_FRAC_BITS + 2;
  localparam logic signed [PLO_W-1:0] HALF =
    PLO_W'(64'd1 << (RECIP_FRAC_BITS - 1));
  localparam logic signed [RES_W-1:0] SAT_MAX =
    {{(RES_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] SAT_MIN =
    {{(RES_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

  logic                      v3;
  logic signed [PHI_W-1:0]   p_hi;
  logic signed [PLO_W-1:0]   p_lo;
  logic                      last3;
  logic                      fire3;
  logic                      out_free;

  logic signed [HI_W-1:0]        hi_part;
  logic signed [SPLIT_BITS:0]    lo_part;
  logic signed [PLO_W-1:0]       lo_sum;
  logic signed [RES_W-1:0]       hi_term;
  logic signed [RES_W-1:0]       lo_term;
  logic signed [RES_W-1:0]       res;
  logic signed [SAMPLE_W-1:0]    sat_value;

  assign out_free = !out_valid || out_ready;
  assign fire3    = v3 && out_free;
  assign in_ready = !v3 || fire3;

  // Split the sum: signed upper half, unsigned lower half
  assign hi_part = in_item.sum[SUM_W-1:SPLIT_BITS];
  assign lo_part = {1'b0, in_item.sum[SPLIT_BITS-1:0]};

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (in_ready) begin
      v3 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      p_hi  <= hi_part * recip;
      p_lo  <= lo_part * recip;
      last3 <= in_item.last;
    end
  end

  // Recombine, round the low part to nearest, clamp to 32 bits
  always_comb begin
    hi_term = RES_W'(p_hi) <<< (SPLIT_BITS - RECIP_FRAC_BITS);
    lo_sum  = p_lo + HALF;
    lo_term = RES_W'(lo_sum >>> RECIP_FRAC_BITS);
    res     = hi_term + lo_term;
    if (res > SAT_MAX) begin
      sat_value = SAT_MAX[SAMPLE_W-1:0];
    end else if (res < SAT_MIN) begin
      sat_value = SAT_MIN[SAMPLE_W-1:0];
    end else begin
      sat_value = res[SAMPLE_W-1:0];
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (fire3) begin
      out_value <= sat_value;
      out_last  <= last3;
    end
  end

endmodule

### sv/centered_sliding_sum_core.sv
// Centered sliding-sum box filter, Q16.16 stream in and out.
// Result path: sum update stage, sum snapshot, scaler product stage, output word register.
// One word per cycle unless stalled; the delay line is read per word, written on shifts.
// Reset: clears counts, write pointer, running sum and all stage valids; sets
// window_size to 100 and denom_reciprocal to 1.0. Delay line contents are not cleared.
`timescale 1ns / 1ps

module centered_sliding_sum_core import css_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  // slave side
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [SAMPLE_W-1:0]   s_tdata,   // [31:0] sample
  input  logic [CMD_W-1:0]      s_tuser,   // [1:0] command
  // master side
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [SAMPLE_W-1:0]   m_tdata,   // [31:0] value
  output logic                  m_tlast,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PTR_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int EW    = (CNT_W > WIN_W) ? CNT_W : WIN_W;
  localparam int AW    = EW + 1;
  localparam logic [EW-1:0] DEPTH_E = EW'(WINDOW_DEPTH);

  // Configuration registers
  logic [WIN_W-1:0]          window_size;
  logic signed [RECIP_W-1:0] denom_recip;

  // Stream control state
  logic [PTR_W-1:0]  wptr;
  logic [CNT_W-1:0]  pos_count;
  logic [PEND_W-1:0] pending;
  logic [PEND_W-1:0] pending_next;

  // Delay line
  logic [SAMPLE_W-1:0] delay_mem [WINDOW_DEPTH];

  // Accept-side decode
  logic                 acc;
  logic                 do_shift;
  logic                 do_clear;
  logic                 do_emit;
  logic                 is_last;
  logic [SAMPLE_W-1:0]  shift_word;
  logic [WIN_W-1:0]     w_eff;
  logic [WIN_W-1:0]     w_minus1;
  logic [PEND_W-1:0]    hoff;
  logic [EW-1:0]        w_ext;
  logic [AW-1:0]        wp_e;
  logic [AW-1:0]        w_e;
  logic [AW-1:0]        addr_diff;
  logic [PTR_W-1:0]     rd_addr;
  logic                 use_old;

  // Stage 1: sum update
  logic                        v1;
  logic                        clr1;
  logic                        emit1;
  logic                        last1;
  logic                        old1;
  logic signed [SAMPLE_W-1:0]  x1;
  logic signed [SAMPLE_W-1:0]  rd1;
  logic                        fire1;
  logic                        free1;
  logic signed [SUM_W-1:0]     running_sum;
  logic signed [SUM_W-1:0]     sum_next;

  // Stage 2: sum snapshot for the scaler
  logic       v2;
  css_item_t  item2;
  logic       fire2;
  logic       free2;
  logic       scale_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      denom_recip <= RECIP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE: window_size <= cfg_wdata[WIN_W-1:0];
        REG_DENOM_RECIP: denom_recip <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Clamp the window and derive the half offset
  always_comb begin
    w_ext = EW'(window_size);
    if (window_size < WINDOW_MIN) begin
      w_eff = WINDOW_MIN;
    end else if (w_ext > DEPTH_E) begin
      w_eff = DEPTH_E[WIN_W-1:0];
    end else begin
      w_eff = window_size;
    end
    w_minus1 = w_eff - WIN_W'(1);
    hoff     = w_minus1[WIN_W-1:1];
  end

  // Address of the sample leaving the window
  always_comb begin
    wp_e = AW'(wptr);
    w_e  = AW'(w_eff);
    if (wp_e >= w_e) begin
      addr_diff = wp_e - w_e;
    end else begin
      addr_diff = wp_e + AW'(WINDOW_DEPTH) - w_e;
    end
    rd_addr = addr_diff[PTR_W-1:0];
    use_old = EW'(pos_count) >= EW'(w_eff);
  end

  // Decode the incoming word
  assign acc = s_tvalid && s_tready;

  always_comb begin
    do_shift     = 1'b0;
    do_clear     = 1'b0;
    do_emit      = 1'b0;
    is_last      = 1'b0;
    shift_word   = s_tdata;
    pending_next = pending;
    case (s_tuser)
      CMD_SAMPLE: begin
        do_shift = 1'b1;
        if (pending < hoff) begin
          pending_next = pending + PEND_W'(1);
        end else begin
          do_emit = 1'b1;
        end
      end
      CMD_TAIL: begin
        if (pending != '0) begin
          do_shift     = 1'b1;
          do_emit      = 1'b1;
          shift_word   = '0;
          pending_next = pending - PEND_W'(1);
          is_last      = (pending_next == '0);
        end
      end
      CMD_CLEAR: begin
        do_clear = 1'b1;
      end
      default: ;
    endcase
  end

  // Advance pointer and fill count on shifts, pending on accepted words; clear zeroes them
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr      <= '0;
      pos_count <= '0;
      pending   <= '0;
    end else if (acc) begin
      if (do_clear) begin
        wptr      <= '0;
        pos_count <= '0;
        pending   <= '0;
      end else begin
        pending <= pending_next;
        if (do_shift) begin
          if (wptr == PTR_W'(WINDOW_DEPTH - 1)) begin
            wptr <= '0;
          end else begin
            wptr <= wptr + PTR_W'(1);
          end
          if (pos_count != CNT_W'(WINDOW_DEPTH)) begin
            pos_count <= pos_count + CNT_W'(1);
          end
        end
      end
    end
  end

  // Delay line: write the new sample, read the leaving one (old data on collision)
  always_ff @(posedge clk) begin
    if (acc && do_shift) begin
      delay_mem[wptr] <= shift_word;
    end
    if (acc) begin
      rd1 <= delay_mem[rd_addr];
    end
  end

  // Stage 1 handshake
  assign fire1    = v1 && (!emit1 || free2);
  assign free1    = !v1 || fire1;
  assign s_tready = free1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (free1) begin
      v1 <= acc && (do_shift || do_clear);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      clr1  <= do_clear;
      emit1 <= do_emit;
      last1 <= is_last;
      old1  <= use_old;
      x1    <= shift_word;
    end
  end

  // Running sum: add the new sample, drop the one that left
  assign sum_next = running_sum + SUM_W'(x1) - (old1 ? SUM_W'(rd1) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
    end else if (fire1) begin
      running_sum <= clr1 ? '0 : sum_next;
    end
  end

  // Stage 2: hold the sum for the scaler
  assign fire2 = v2 && scale_ready;
  assign free2 = !v2 || fire2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (free2) begin
      v2 <= fire1 && emit1;
    end
  end

  always_ff @(posedge clk) begin
    if (fire1 && emit1) begin
      item2.sum  <= sum_next;
      item2.last <= last1;
    end
  end

  css_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_ready  (scale_ready),
    .in_item   (item2),
    .recip     (denom_recip),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

### sv/css_check.sv
// Port-level checks of the centered sliding-sum core, bound to the top level.
// Depends on centered_sliding_sum_core_macros.svh.
`timescale 1ns / 1ps
`include "centered_sliding_sum_core_macros.svh"

module css_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // A stalled result word holds its value
  `CSS_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

  // Reset empties the output register
  `CSS_ASSERT_ALWAYS_NEXT(a_rst_empty, clk, rst, !m_tvalid, "result word valid right after reset")

  // With the output register empty no stage can block the input
  `CSS_ASSERT_NOW(a_ready_when_empty, clk, rst, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind centered_sliding_sum_core css_check u_css_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

### test/centered_sliding_sum_core_test.sv
// Self-checking testbench for centered_sliding_sum_core: directed and random vectors
// checked against a cycle-free prediction of the box filter. Depends on css_pkg.
`timescale 1ns / 1ps

module centered_sliding_sum_core_test;
  import css_pkg::*;

  localparam int DEPTH       = DEF_WINDOW_DEPTH;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 8;
  localparam int VEC_CAP     = 24;
  localparam int WORD_BUDGET = 770;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // Window sum prediction and the queue of words still owed by the block
  class sliding_sum_board;
    typedef struct packed {
      logic [SAMPLE_W-1:0] value;
      logic                last;
    } result_t;

    logic [WIN_W-1:0]          window_reg;
    logic signed [RECIP_W-1:0] recip_reg;
    logic [SAMPLE_W-1:0]       taps [DEPTH];
    logic [SUM_W-1:0]          acc;
    int                        fill;
    int                        owed;
    int                        wr_ptr;
    int                        errors;
    result_t                   expected_q [$];

    function new();
      foreach (taps[i]) taps[i] = '0;
      window_reg = WINDOW_RESET;
      recip_reg  = RECIP_RESET;
      errors     = 0;
      clear_vector();
    endfunction

    function void clear_vector();
      acc    = '0;
      fill   = 0;
      owed   = 0;
      wr_ptr = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_WINDOW_SIZE) window_reg = data[WIN_W-1:0];
      else if (idx == REG_DENOM_RECIP) recip_reg = data[RECIP_W-1:0];
    endfunction

    // Clamp the window register into the usable range
    function int span();
      int w;
      w = int'(window_reg);
      if (w < WINDOW_MIN) w = int'(WINDOW_MIN);
      if (w > DEPTH) w = DEPTH;
      return w;
    endfunction

    // Shift one sample in and drop the one leaving the window
    function void push_tap(logic [SAMPLE_W-1:0] x, int w);
      logic [SAMPLE_W-1:0] old;
      old = '0;
      if (fill >= w) old = taps[(wr_ptr + DEPTH - w) % DEPTH];
      taps[wr_ptr] = x;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (fill < DEPTH) fill++;
      acc = acc + {{(SUM_W-SAMPLE_W){x[SAMPLE_W-1]}}, x}
                - {{(SUM_W-SAMPLE_W){old[SAMPLE_W-1]}}, old};
    endfunction

    // Sum times reciprocal, round half up, saturate to 32 bits
    function logic [SAMPLE_W-1:0] scaled();
      logic signed [SUM_W-1:0] s;
      logic signed [79:0]      p;
      s = acc;
      p = s * recip_reg;
      p = (p + (80'sd1 <<< (RECIP_FRAC_BITS - 1))) >>> RECIP_FRAC_BITS;
      if (p > 80'sd2147483647) return 32'h7FFF_FFFF;
      if (p < -80'sd2147483648) return 32'h8000_0000;
      return p[SAMPLE_W-1:0];
    endfunction

    // Note an accepted input word; returns 1 if the block acts on it
    function bit note_word(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp);
      int      w;
      int      hoff;
      result_t r;
      w    = span();
      hoff = (w - 1) / 2;
      case (cmd)
        CMD_SAMPLE: begin
          push_tap(smp, w);
          if (owed < hoff) begin
            owed++;
            return 1'b1;
          end
          r.value = scaled();
          r.last  = 1'b0;
          expected_q.push_back(r);
          return 1'b1;
        end
        CMD_TAIL: begin
          if (owed == 0) return 1'b0;
          push_tap('0, w);
          owed--;
          r.value = scaled();
          r.last  = (owed == 0);
          expected_q.push_back(r);
          return 1'b1;
        end
        CMD_CLEAR: begin
          clear_vector();
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // Compare an output word with the oldest prediction
    function void check_word(logic [SAMPLE_W-1:0] value, logic last);
      result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual value %h last %b",
                 $time, value, last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (want.value !== value) begin
        $display("%0t: value mismatch, expected %h actual %h", $time, want.value, value);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last mismatch, expected %b actual %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [SAMPLE_W-1:0]   s_tdata   = '0;
  logic [CMD_W-1:0]      s_tuser   = CMD_SAMPLE;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [SAMPLE_W-1:0]   m_tdata;
  logic                  m_tlast;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sliding_sum_board board = new();
  int idle_pct   = 0;
  int stall_pct  = 0;
  int words_done = 0;
  int quiet      = 0;
  int phase_no   = 0;

  centered_sliding_sum_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Check every accepted output word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tlast);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("centered_sliding_sum_core_test: FAIL");
      $finish;
    end
  end

  // Present one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= smp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (board.note_word(cmd, smp)) words_done++;
  endtask

  // Stop sending and wait for every owed word plus the pipeline depth
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    board.set_reg(idx, data);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2, 3: v = $urandom_range(2000) - 32'd1000;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_recip();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(9))
      0: v = 24'h7F_FFFF;
      1: v = 24'h80_0000;
      2: v = 24'h01_0000;
      3: v = 24'hFF_0000;
      4: v = 24'h00_0000;
      5: v = 24'h00_5555;
      default: v = CFG_DATA_W'($urandom);
    endcase
    return v;
  endfunction

  // One vector: samples with some noise, then tail ticks
  task automatic run_vector(input int n, input bit flush);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 3) send_word(CMD_UNUSED, $urandom);
      else if (r < 6) send_word(CMD_TAIL, $urandom);
      else send_word(CMD_SAMPLE, pick_sample());
    end
    if ($urandom_range(3) == 0) drain();
    if (flush) begin
      while (board.owed != 0) begin
        if ($urandom_range(19) == 0) send_word(CMD_SAMPLE, pick_sample());
        else send_word(CMD_TAIL, $urandom);
      end
      repeat ($urandom_range(1)) send_word(CMD_TAIL, $urandom);
    end else begin
      repeat ($urandom_range(board.owed)) send_word(CMD_TAIL, $urandom);
    end
  endtask

  // Configure, then run a few vectors under one idling mode
  task automatic run_phase(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] recip);
    int n_vec;
    int w;
    case (phase_no % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 57; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 57; end
      default: begin idle_pct = 14; stall_pct = 14; end
    endcase
    phase_no++;
    write_reg(REG_WINDOW_SIZE, win);
    write_reg(REG_DENOM_RECIP, recip);
    w = board.span();
    n_vec = $urandom_range(2, 4);
    for (int v = 0; v < n_vec; v++) begin
      // the first vector sometimes carries on the previous state
      if (v != 0 || $urandom_range(3) != 0) send_word(CMD_CLEAR, $urandom);
      run_vector($urandom_range(1, (3 * w + 4 > VEC_CAP) ? VEC_CAP : 3 * w + 4),
                 (v != n_vec - 1) || ($urandom_range(2) != 0));
    end
    drain();
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] fixed_win [13];
    fixed_win = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd9, 24'd16, 24'd33,
                  24'd255, 24'd1023, 24'd1024, 24'd2047};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: smallest window, saturation both ways, ignored words, short vectors
    write_reg(REG_WINDOW_SIZE, 24'd0);
    write_reg(REG_DENOM_RECIP, 24'h01_0000);
    send_word(CMD_CLEAR, 32'h0);
    repeat (4) send_word(CMD_SAMPLE, 32'h7FFF_FFFF);
    repeat (4) send_word(CMD_SAMPLE, 32'h8000_0000);
    send_word(CMD_SAMPLE, 32'h0);
    send_word(CMD_UNUSED, 32'hFFFF_FFFF);
    repeat (3) send_word(CMD_TAIL, 32'h0);
    send_word(CMD_CLEAR, 32'hFFFF_FFFF);
    send_word(CMD_TAIL, 32'h0);
    send_word(CMD_SAMPLE, 32'h1);
    send_word(CMD_TAIL, 32'h0);
    send_word(CMD_SAMPLE, 32'hFFFF_FFFF);
    send_word(CMD_SAMPLE, 32'h5);
    send_word(CMD_TAIL, 32'h0);
    drain();

    // Fixed window sweep, extremes and clamp above depth included
    foreach (fixed_win[i]) run_phase(fixed_win[i], pick_recip());

    // Random settings, mostly small windows
    while (words_done < WORD_BUDGET) begin
      case ($urandom_range(19))
        0: run_phase(CFG_DATA_W'($urandom_range(2)), pick_recip());
        1: run_phase(CFG_DATA_W'($urandom_range(41, 300)), pick_recip());
        default: run_phase(CFG_DATA_W'($urandom_range(3, 40)), pick_recip());
      endcase
    end

    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("centered_sliding_sum_core_test: PASS");
    end else begin
      $display("centered_sliding_sum_core_test: FAIL");
    end
    $finish;
  end

endmodule
